// ----- design/segregated_pow2_block_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the segregated power-of-two block allocator
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SEGREGATED_POW2_BLOCK_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_POW2_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPBA_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPBA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/spba_pkg.sv -----
// ----------------------------------------------------------------------------
// spba_pkg
// Shared types and constants of the segregated power-of-two block allocator.
// ----------------------------------------------------------------------------
package spba_pkg;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_SIZE  = 2'd2,
    FN_COUNT = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ZERO  = 3'd1,
    ST_LARGE = 3'd2,
    ST_FULL  = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_END   = 1'b1;

  localparam logic [31:0] HEAP_START_RST = 32'h0000_0000;
  localparam logic [31:0] HEAP_END_RST   = 32'h0004_0000;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic decode;
    logic lookup;
    logic access;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_access;
  } dp_sts_t;

endpackage

// ----- design/spba_ctrl.sv -----
// ----------------------------------------------------------------------------
// spba_ctrl
// Sequencer: steps one transaction through decode, lookup, access (when the lookup asks for it), commit.
// ----------------------------------------------------------------------------
module spba_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  spba_pkg::dp_sts_t sts,
  output spba_pkg::dp_cmd_t cmd
);
  import spba_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_ACCESS = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_DECODE;
      S_DECODE: state_nxt = S_LOOKUP;
      S_LOOKUP: state_nxt = sts.need_access ? S_ACCESS : S_COMMIT;
      S_ACCESS: state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && start;
  assign cmd.decode = (state_r == S_DECODE);
  assign cmd.lookup = (state_r == S_LOOKUP);
  assign cmd.access = (state_r == S_ACCESS);
  assign cmd.commit = (state_r == S_COMMIT);

endmodule

// ----- design/spba_dp.sv -----
// ----------------------------------------------------------------------------
// spba_dp
// Datapath: config registers, class tables, counters, heap word store and
// result registers.
// ----------------------------------------------------------------------------
module spba_dp #(
  parameter int HEAP_WORDS     = 65536,
  parameter int MIN_CLASS_LOG2 = 4,
  parameter int MAX_CLASS_LOG2 = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  spba_pkg::dp_cmd_t                  cmd,
  output spba_pkg::dp_sts_t                  sts,
  input  logic                               cfg_we,
  input  logic [spba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data,
  input  logic [1:0]                         in_func,
  input  logic [31:0]                        in_request_bytes,
  input  logic [31:0]                        in_block_address,
  input  logic [3:0]                         in_class_index,
  output logic                               out_valid,
  output logic [31:0]                        out_result_address,
  output logic [16:0]                        out_block_bytes,
  output logic [15:0]                        out_class_free_count,
  output logic [31:0]                        out_live_blocks,
  output logic [31:0]                        out_total_allocations,
  output logic [31:0]                        out_bump_bytes_left,
  output logic [2:0]                         out_status
);
  import spba_pkg::*;

  localparam int NCLASS = MAX_CLASS_LOG2 - MIN_CLASS_LOG2 + 1;
  localparam int CW     = (NCLASS > 1) ? $clog2(NCLASS) : 1;
  localparam int KW     = $clog2(MAX_CLASS_LOG2 + 1);
  localparam int AW     = $clog2(HEAP_WORDS);
  localparam logic [29:0] HW30   = 30'(HEAP_WORDS);
  localparam logic [31:0] NCL32  = 32'(NCLASS);
  localparam logic [KW-1:0] KMIN = KW'(MIN_CLASS_LOG2);

  function automatic logic [KW-1:0] bit_len(input logic [MAX_CLASS_LOG2-1:0] v);
    logic [KW-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_CLASS_LOG2; i++) begin
      if (v[i]) n = KW'(i + 1);
    end
    return n;
  endfunction

  // Control state
  logic [31:0] heap_start_r, heap_end_r, bump_r, live_r, total_r;
  logic [31:0] head_tbl_r [NCLASS];
  logic [15:0] cnt_tbl_r  [NCLASS];
  logic        out_valid_r;

  // Per-transaction payload
  func_t       func_r;
  logic [31:0] req_m1_r, addr_r, hdr_off_r;
  logic        req_zero_r;
  logic [3:0]  cidx_r;
  logic [KW-1:0] k_r;
  logic [CW-1:0] class_r, tidx_r;
  logic        large_r, hi_ok_r, link_ok_r;
  logic [31:0] head_r, bump_next_r;
  logic [15:0] cnt_r;
  logic [16:0] bytes_r;
  logic        pop_r, pop_in_r;
  status_t     status_r;

  // Heap word store
  logic [31:0] mem [HEAP_WORDS];
  logic [31:0] mem_rdata_r;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [31:0] mem_wdata;
  logic        mem_re, mem_we;

  // Result registers
  logic [31:0] res_addr_r, res_live_r, res_total_r, res_left_r;
  logic [16:0] res_bytes_r;
  logic [15:0] res_cnt_r;
  status_t     res_status_r;

  // ---------------- decode ----------------
  logic [KW-1:0] blen, k_dec;
  logic [29:0]   hdr_word;
  assign blen     = bit_len(req_m1_r[MAX_CLASS_LOG2-1:0]);
  assign k_dec    = (blen < KMIN) ? KMIN : blen;
  assign hdr_word = hdr_off_r[31:2];

  // ---------------- lookup ----------------
  logic [31:0] rd;
  logic [CW-1:0] tidx;
  logic [31:0] tbl_head;
  logic [15:0] tbl_cnt;
  logic        hcls_ok, q_ok;
  logic [32:0] bump_sum;
  logic        full;
  logic [31:0] one_sh;
  status_t     status_nxt;

  assign rd      = mem_rdata_r;
  assign hcls_ok = rd < NCL32;
  assign q_ok    = {28'd0, cidx_r} < NCL32;

  always_comb begin
    case (func_r)
      FN_ALLOC: tidx = class_r;
      FN_FREE:  tidx = rd[CW-1:0];
      default:  tidx = CW'(cidx_r);
    endcase
  end

  assign tbl_head = head_tbl_r[tidx];
  assign tbl_cnt  = cnt_tbl_r[tidx];
  assign bump_sum = {1'b0, bump_r} + (33'd1 << k_r) + 33'd4;
  assign full     = bump_sum >= {1'b0, heap_end_r};
  assign one_sh   = 32'd1 << (MIN_CLASS_LOG2 + int'(rd[CW-1:0]));

  always_comb begin
    status_nxt = ST_OK;
    case (func_r)
      FN_ALLOC: begin
        if (req_zero_r)          status_nxt = ST_ZERO;
        else if (large_r)        status_nxt = ST_LARGE;
        else if (tbl_cnt == '0 && full) status_nxt = ST_FULL;
      end
      FN_FREE: begin
        if (!link_ok_r || !hcls_ok || (&tbl_cnt)) status_nxt = ST_RANGE;
      end
      FN_SIZE: begin
        if (!hi_ok_r || !hcls_ok) status_nxt = ST_RANGE;
      end
      default: begin
        if (!q_ok) status_nxt = ST_RANGE;
      end
    endcase
  end

  assign sts.need_access = (status_nxt == ST_OK) && (func_r == FN_ALLOC || func_r == FN_FREE);

  // ---------------- access ----------------
  logic [31:0] pop_off, bump_off;
  logic [29:0] pop_word, bump_word;
  assign pop_off   = head_r - heap_start_r;
  assign bump_off  = bump_r - heap_start_r;
  assign pop_word  = pop_off[31:2];
  assign bump_word = bump_off[31:2];

  always_comb begin
    mem_re    = cmd.decode || (cmd.access && pop_r);
    mem_raddr = cmd.decode ? hdr_word[AW-1:0] : pop_word[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = bump_word[AW-1:0];
    mem_wdata = 32'(class_r);
    if (cmd.access && status_r == ST_OK) begin
      if (func_r == FN_FREE) begin
        mem_we    = 1'b1;
        mem_waddr = AW'(hdr_word + 30'd1);
        mem_wdata = head_r;
      end else if (func_r == FN_ALLOC && !pop_r) begin
        mem_we    = bump_word < HW30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[mem_raddr];
  end

  // ---------------- commit ----------------
  logic        ok, do_alloc, do_free;
  logic [31:0] live_nxt, total_nxt, bump_nxt, alloc_addr;
  assign ok         = (status_r == ST_OK);
  assign do_alloc   = ok && func_r == FN_ALLOC;
  assign do_free    = ok && func_r == FN_FREE;
  assign live_nxt   = live_r + 32'(do_alloc) - 32'(do_free);
  assign total_nxt  = total_r + 32'(do_alloc);
  assign bump_nxt   = (do_alloc && !pop_r) ? bump_next_r : bump_r;
  assign alloc_addr = pop_r ? head_r : (bump_r + 32'd4);

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_start_r <= HEAP_START_RST;
      heap_end_r   <= HEAP_END_RST;
      bump_r       <= HEAP_START_RST;
      live_r       <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NCLASS; i++) begin
        head_tbl_r[i] <= '0;
        cnt_tbl_r[i]  <= '0;
      end
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.commit) begin
        live_r  <= live_nxt;
        total_r <= total_nxt;
        bump_r  <= bump_nxt;
        if (do_alloc && pop_r) begin
          head_tbl_r[tidx_r] <= pop_in_r ? mem_rdata_r : 32'd0;
          cnt_tbl_r[tidx_r]  <= cnt_r - 16'd1;
        end else if (do_free) begin
          head_tbl_r[tidx_r] <= addr_r;
          cnt_tbl_r[tidx_r]  <= cnt_r + 16'd1;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_HEAP_START: begin
            heap_start_r <= cfg_data;
            bump_r       <= cfg_data;
          end
          REG_HEAP_END: heap_end_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r     <= func_t'(in_func);
      req_m1_r   <= in_request_bytes - 32'd1;
      req_zero_r <= (in_request_bytes == '0);
      addr_r     <= in_block_address;
      hdr_off_r  <= in_block_address - heap_start_r - 32'd4;
      cidx_r     <= in_class_index;
    end
    if (cmd.decode) begin
      k_r       <= k_dec;
      class_r   <= CW'(k_dec - KMIN);
      large_r   <= |(req_m1_r >> MAX_CLASS_LOG2);
      hi_ok_r   <= (addr_r != '0) && (hdr_word < HW30);
      link_ok_r <= (addr_r != '0) && (hdr_word < HW30 - 30'd1);
    end
    if (cmd.lookup) begin
      tidx_r      <= tidx;
      head_r      <= tbl_head;
      cnt_r       <= tbl_cnt;
      pop_r       <= (func_r == FN_ALLOC) && (tbl_cnt != '0);
      bump_next_r <= bump_sum[31:0];
      bytes_r     <= one_sh[16:0];
      status_r    <= status_nxt;
    end
    if (cmd.access) begin
      pop_in_r <= pop_word < HW30;
    end
    if (cmd.commit) begin
      res_addr_r   <= do_alloc ? alloc_addr : 32'd0;
      res_bytes_r  <= (ok && func_r == FN_SIZE) ? bytes_r : 17'd0;
      res_cnt_r    <= (ok && func_r == FN_COUNT) ? cnt_r : 16'd0;
      res_live_r   <= live_nxt;
      res_total_r  <= total_nxt;
      res_left_r   <= heap_end_r - bump_nxt;
      res_status_r <= status_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_address    = res_addr_r;
  assign out_block_bytes       = res_bytes_r;
  assign out_class_free_count  = res_cnt_r;
  assign out_live_blocks       = res_live_r;
  assign out_total_allocations = res_total_r;
  assign out_bump_bytes_left   = res_left_r;
  assign out_status            = res_status_r;

endmodule

// ----- design/segregated_pow2_block_allocator.sv -----
// ----------------------------------------------------------------------------
// segregated_pow2_block_allocator
// Heap allocator with one LIFO free list per power-of-two size class and a
// bump pointer behind them; also answers block size and class count queries.
// ----------------------------------------------------------------------------
//
//   channel   handshake                 payload
//   --------  ------------------------  ------------------------------------
//   input     start & !busy             in_func, in_request_bytes,
//                                       in_block_address, in_class_index
//   result    out_valid (one cycle)     out_result_address, out_block_bytes,
//                                       out_class_free_count, out_live_blocks,
//                                       out_total_allocations,
//                                       out_bump_bytes_left, out_status
//   config    cfg_valid & cfg_ready     cfg_index, cfg_data
//
// Steps: a transaction walks decode, lookup, (access), commit. Allocate and
// free that pass their checks take the access step; queries and refused
// requests skip it. The steps follow the registered reads of the heap word
// store: the header word is read before the class tables, and a pop reads
// the link word before the new head. The result strobe comes in the cycle
// after commit, which is also the first cycle busy is low again, so a new
// start can be taken while it is shown.
// Reset (rst_n low, synchronous) clears counters, class tables and restores
// the default heap bounds; the heap word store holds no reset value.
// The receiver cannot stall: each result is shown exactly once.
//
module segregated_pow2_block_allocator #(
  parameter int HEAP_WORDS     = 65536,
  parameter int MIN_CLASS_LOG2 = 4,
  parameter int MAX_CLASS_LOG2 = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input transactions
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_func,
  input  logic [31:0]                    in_request_bytes,
  input  logic [31:0]                    in_block_address,
  input  logic [3:0]                     in_class_index,
  // results
  output logic                           out_valid,
  output logic [31:0]                    out_result_address,
  output logic [16:0]                    out_block_bytes,
  output logic [15:0]                    out_class_free_count,
  output logic [31:0]                    out_live_blocks,
  output logic [31:0]                    out_total_allocations,
  output logic [31:0]                    out_bump_bytes_left,
  output logic [2:0]                     out_status,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import spba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The user must make config writes land only while idle; the block does not enforce it and takes them at once.
  assign cfg_ready = 1'b1;

  // Sequence each transaction.
  spba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Hold the tables, the heap store and the result registers.
  spba_dp #(
    .HEAP_WORDS     (HEAP_WORDS),
    .MIN_CLASS_LOG2 (MIN_CLASS_LOG2),
    .MAX_CLASS_LOG2 (MAX_CLASS_LOG2)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_func               (in_func),
    .in_request_bytes      (in_request_bytes),
    .in_block_address      (in_block_address),
    .in_class_index        (in_class_index),
    .out_valid             (out_valid),
    .out_result_address    (out_result_address),
    .out_block_bytes       (out_block_bytes),
    .out_class_free_count  (out_class_free_count),
    .out_live_blocks       (out_live_blocks),
    .out_total_allocations (out_total_allocations),
    .out_bump_bytes_left   (out_bump_bytes_left),
    .out_status            (out_status)
  );

endmodule

// ----- design/spba_checker.sv -----
// ----------------------------------------------------------------------------
// spba_checker
// Port-level checks of the allocator's transaction sequencing.
// ----------------------------------------------------------------------------
`include "segregated_pow2_block_allocator_assert.svh"

module spba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_result_address,
  input logic [16:0] out_block_bytes,
  input logic [2:0]  out_status
);
  import spba_pkg::*;

  `SPBA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_valid,
    "accepted transaction did not raise busy")
  `SPBA_ASSERT_NOW(a_done_strobe, clk, rst_n, $fell(busy) && $past(rst_n), out_valid,
    "busy dropped without a result strobe")
  `SPBA_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid, !busy,
    "result strobe while still busy")
  `SPBA_ASSERT_NOW(a_fail_null, clk, rst_n, out_valid && out_status != ST_OK,
    out_result_address == 32'd0 && out_block_bytes == 17'd0,
    "refused transaction returned an address or size")

endmodule

bind segregated_pow2_block_allocator spba_checker u_spba_checker (.*);

// ----- test/tb_segregated_pow2_block_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segregated_pow2_block_allocator
// Self-checking bench for the segregated power-of-two block allocator. A
// planner fills a queue of commands phase by phase, keeping its own copy of
// the heap state so that no command reads a heap word that was never written.
// A clocked driver issues the queue and predicts each accepted transaction on
// a second copy of that state; a clocked monitor checks every result strobe
// field by field against the oldest prediction. The heap bounds are rewritten
// between phases, covering the reset bounds, a stale upper heap, an unbounded
// end and an empty heap at the top of the address space.
// ----------------------------------------------------------------------------
module tb_segregated_pow2_block_allocator;
  import spba_pkg::*;

  localparam int HEAP_WORDS     = 65536;
  localparam int MIN_CLASS_LOG2 = 4;
  localparam int MAX_CLASS_LOG2 = 16;
  localparam int NCLASS         = MAX_CLASS_LOG2 - MIN_CLASS_LOG2 + 1;
  localparam int CYCLE_LIMIT    = 2000000;
  localparam int RANDOM_ITEMS   = 620;

  // Two copies of the heap state: one runs ahead while commands are planned,
  // the other follows the transactions the block accepts.
  localparam int COPY_PLAN = 0;
  localparam int COPY_DUT  = 1;

  typedef struct packed {
    func_t       func;
    logic [31:0] req;
    logic [31:0] addr;
    logic [3:0]  cls;
  } heap_cmd_t;

  typedef struct packed {
    logic [31:0] address;
    logic [16:0] bytes;
    logic [15:0] free_cnt;
    logic [31:0] live;
    logic [31:0] allocs;
    logic [31:0] bump_left;
    status_t     status;
  } heap_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = 2'd0;
  logic [31:0] in_request_bytes = 32'd0;
  logic [31:0] in_block_address = 32'd0;
  logic [3:0]  in_class_index = 4'd0;
  logic        out_valid;
  logic [31:0] out_result_address;
  logic [16:0] out_block_bytes;
  logic [15:0] out_class_free_count;
  logic [31:0] out_live_blocks;
  logic [31:0] out_total_allocations;
  logic [31:0] out_bump_bytes_left;
  logic [2:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = 32'd0;

  // Heap state, indexed by copy.
  bit [31:0] hp_start   [2];
  bit [31:0] hp_end     [2];
  bit [31:0] hp_bump    [2];
  bit [31:0] hp_live    [2];
  bit [31:0] hp_allocs  [2];
  bit [31:0] hp_head    [2][NCLASS];
  bit [15:0] hp_count   [2][NCLASS];
  bit [31:0] hp_word    [2][HEAP_WORDS];
  bit        hp_written [2][HEAP_WORDS];

  heap_cmd_t   pending_cmds[$];
  heap_reply_t predicted_replies[$];
  logic [31:0] live_addrs[$];
  logic [31:0] freed_addrs[$];
  heap_cmd_t   cur_cmd;
  int          cmds_planned = 0;
  int          replies_seen = 0;
  int          err_count = 0;
  int          send_idle_pct = 8;
  int          cycle_count = 0;

  segregated_pow2_block_allocator #(
    .HEAP_WORDS    (HEAP_WORDS),
    .MIN_CLASS_LOG2(MIN_CLASS_LOG2),
    .MAX_CLASS_LOG2(MAX_CLASS_LOG2)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_func              (in_func),
    .in_request_bytes     (in_request_bytes),
    .in_block_address     (in_block_address),
    .in_class_index       (in_class_index),
    .out_valid            (out_valid),
    .out_result_address   (out_result_address),
    .out_block_bytes      (out_block_bytes),
    .out_class_free_count (out_class_free_count),
    .out_live_blocks      (out_live_blocks),
    .out_total_allocations(out_total_allocations),
    .out_bump_bytes_left  (out_bump_bytes_left),
    .out_status           (out_status),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Word of the heap store that a byte address maps to, relative to the start.
  function automatic int unsigned word_of(int mi, logic [31:0] addr);
    logic [31:0] off;
    off = addr - hp_start[mi];
    return off >> 2;
  endfunction

  // Header word of a user address; a zero return means null or off the store.
  function automatic bit header_slot(int mi, logic [31:0] addr, bit need_link,
                                     output int unsigned hi);
    logic [31:0] off;
    off = addr - hp_start[mi] - 32'd4;
    hi = off >> 2;
    if (addr == 32'd0) return 1'b0;
    if (hi >= HEAP_WORDS) return 1'b0;
    if (need_link && hi + 1 >= HEAP_WORDS) return 1'b0;
    return 1'b1;
  endfunction

  // Round a request up to a power of two, never below the smallest class.
  function automatic int size_log2(logic [31:0] n);
    logic [31:0] v;
    int          k;
    v = n - 32'd1;
    k = 0;
    while (v != 32'd0) begin
      k++;
      v = v >> 1;
    end
    if (k < MIN_CLASS_LOG2) k = MIN_CLASS_LOG2;
    return k;
  endfunction

  function automatic void heap_reset();
    for (int mi = 0; mi < 2; mi++) begin
      hp_start[mi]  = HEAP_START_RST;
      hp_end[mi]    = HEAP_END_RST;
      hp_bump[mi]   = HEAP_START_RST;
      hp_live[mi]   = 32'd0;
      hp_allocs[mi] = 32'd0;
      for (int c = 0; c < NCLASS; c++) begin
        hp_head[mi][c]  = 32'd0;
        hp_count[mi][c] = 16'd0;
      end
    end
  endfunction

  // Register write seen by both copies; a new start also reloads the bump pointer.
  function automatic void heap_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    for (int mi = 0; mi < 2; mi++) begin
      if (idx == REG_HEAP_START) begin
        hp_start[mi] = val;
        hp_bump[mi]  = val;
      end else begin
        hp_end[mi] = val;
      end
    end
  endfunction

  // Advance one copy of the heap by one transaction and return its result.
  function automatic heap_reply_t heap_apply(int mi, heap_cmd_t cmd);
    heap_reply_t r;
    int          k;
    int          c;
    int unsigned hi;
    bit          ok;
    logic [31:0] cw;
    logic [63:0] nxt;
    r = '0;
    r.status = ST_OK;
    case (cmd.func)
      FN_ALLOC: begin
        if (cmd.req == 32'd0) begin
          r.status = ST_ZERO;
        end else begin
          k = size_log2(cmd.req);
          if (k > MAX_CLASS_LOG2) begin
            r.status = ST_LARGE;
          end else begin
            c = k - MIN_CLASS_LOG2;
            if (hp_count[mi][c] != 16'd0) begin
              // Pop: the link word of the head names the next head.
              r.address = hp_head[mi][c];
              hp_count[mi][c] = hp_count[mi][c] - 16'd1;
              hi = word_of(mi, r.address);
              hp_head[mi][c] = (hi < HEAP_WORDS) ? hp_word[mi][hi] : 32'd0;
            end else begin
              nxt = {32'd0, hp_bump[mi]} + (64'd1 << k) + 64'd4;
              if (nxt >= {32'd0, hp_end[mi]}) begin
                r.status = ST_FULL;
              end else begin
                hi = word_of(mi, hp_bump[mi]);
                if (hi < HEAP_WORDS) begin
                  hp_word[mi][hi]    = c;
                  hp_written[mi][hi] = 1'b1;
                end
                r.address   = hp_bump[mi] + 32'd4;
                hp_bump[mi] = nxt[31:0];
              end
            end
            if (r.status == ST_OK) begin
              hp_live[mi]   = hp_live[mi] + 32'd1;
              hp_allocs[mi] = hp_allocs[mi] + 32'd1;
            end
          end
        end
      end
      FN_FREE: begin
        ok = header_slot(mi, cmd.addr, 1'b1, hi);
        if (!ok) begin
          r.status = ST_RANGE;
        end else begin
          cw = hp_word[mi][hi];
          if (cw >= NCLASS) begin
            r.status = ST_RANGE;
          end else if (hp_count[mi][cw] == 16'hFFFF) begin
            r.status = ST_RANGE;
          end else begin
            hp_word[mi][hi + 1]    = hp_head[mi][cw];
            hp_written[mi][hi + 1] = 1'b1;
            hp_head[mi][cw]  = cmd.addr;
            hp_count[mi][cw] = hp_count[mi][cw] + 16'd1;
            hp_live[mi]      = hp_live[mi] - 32'd1;
          end
        end
      end
      FN_SIZE: begin
        ok = header_slot(mi, cmd.addr, 1'b0, hi);
        if (!ok) begin
          r.status = ST_RANGE;
        end else if (hp_word[mi][hi] >= NCLASS) begin
          r.status = ST_RANGE;
        end else begin
          r.bytes = 17'd1 << (MIN_CLASS_LOG2 + hp_word[mi][hi]);
        end
      end
      default: begin
        if (cmd.cls >= NCLASS) r.status = ST_RANGE;
        else r.free_cnt = hp_count[mi][cmd.cls];
      end
    endcase
    r.live      = hp_live[mi];
    r.allocs    = hp_allocs[mi];
    r.bump_left = hp_end[mi] - hp_bump[mi];
    return r;
  endfunction

  // A command is safe when every heap word it reads has been written before.
  function automatic bit cmd_safe(heap_cmd_t cmd);
    int unsigned hi;
    int          c;
    bit          ok;
    case (cmd.func)
      FN_ALLOC: begin
        if (cmd.req == 32'd0) return 1'b1;
        if (size_log2(cmd.req) > MAX_CLASS_LOG2) return 1'b1;
        c = size_log2(cmd.req) - MIN_CLASS_LOG2;
        if (hp_count[COPY_PLAN][c] == 16'd0) return 1'b1;
        hi = word_of(COPY_PLAN, hp_head[COPY_PLAN][c]);
        return (hi >= HEAP_WORDS) || hp_written[COPY_PLAN][hi];
      end
      FN_FREE, FN_SIZE: begin
        ok = header_slot(COPY_PLAN, cmd.addr, cmd.func == FN_FREE, hi);
        return !ok || hp_written[COPY_PLAN][hi];
      end
      default: return 1'b1;
    endcase
  endfunction

  // Build a command; fields the operation ignores carry random bits.
  function automatic heap_cmd_t mk_cmd(func_t f, logic [31:0] v);
    heap_cmd_t c;
    c.func = f;
    c.req  = $urandom;
    c.addr = $urandom;
    c.cls  = 4'($urandom_range(15, 0));
    case (f)
      FN_ALLOC: c.req = v;
      FN_COUNT: c.cls = v[3:0];
      default:  c.addr = v;
    endcase
    return c;
  endfunction

  // Queue a command, turning any unsafe one into a harmless class query.
  function automatic void plan_cmd(heap_cmd_t c);
    heap_reply_t r;
    if (!cmd_safe(c)) c.func = FN_COUNT;
    r = heap_apply(COPY_PLAN, c);
    if (c.func == FN_ALLOC && r.status == ST_OK) live_addrs.push_back(r.address);
    pending_cmds.push_back(c);
    cmds_planned++;
  endfunction

  // Random traffic: mostly alloc/free pairs on live blocks, plus queries,
  // double frees and stray addresses.
  function automatic void plan_random(int n);
    int          pick;
    int          sub;
    int          idx;
    logic [31:0] a;
    repeat (n) begin
      pick = $urandom_range(99, 0);
      if (pick < 40 || live_addrs.size() == 0) begin
        sub = $urandom_range(99, 0);
        if (sub < 70)      a = $urandom_range(64, 1);
        else if (sub < 88) a = $urandom_range(1024, 65);
        else if (sub < 95) a = $urandom_range(65536, 1025);
        else if (sub < 97) a = 32'd0;
        else               a = $urandom;
        plan_cmd(mk_cmd(FN_ALLOC, a));
      end else if (pick < 68) begin
        idx = $urandom_range(live_addrs.size() - 1, 0);
        a = live_addrs[idx];
        live_addrs.delete(idx);
        freed_addrs.push_back(a);
        if (freed_addrs.size() > 32) freed_addrs.delete(0);
        plan_cmd(mk_cmd(FN_FREE, a));
      end else if (pick < 73 && freed_addrs.size() != 0) begin
        plan_cmd(mk_cmd(FN_FREE, freed_addrs[$urandom_range(freed_addrs.size() - 1, 0)]));
      end else if (pick < 83) begin
        plan_cmd(mk_cmd(FN_SIZE, live_addrs[$urandom_range(live_addrs.size() - 1, 0)]));
      end else if (pick < 91) begin
        plan_cmd(mk_cmd(FN_COUNT, $urandom_range(15, 0)));
      end else begin
        case ($urandom_range(3, 0))
          0: a = 32'd0;
          1: a = $urandom;
          2: a = live_addrs[$urandom_range(live_addrs.size() - 1, 0)] + 32'd4;
          default: a = hp_start[COPY_PLAN] + 4 * $urandom_range(HEAP_WORDS, 0);
        endcase
        plan_cmd(mk_cmd($urandom_range(1, 0) ? FN_FREE : FN_SIZE, a));
      end
    end
  endfunction

  // Hold until every planned transaction has produced its result.
  task automatic wait_idle();
    while (replies_seen < cmds_planned) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    heap_config(idx, val);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // Driver: predict each accepted transaction, hold a refused one, otherwise
  // present the next queued command unless this cycle is an idle one.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted_replies.push_back(heap_apply(COPY_DUT, cur_cmd));
      end
      if (start && busy) begin
        // hold the command until the block takes it
      end else if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        cur_cmd = pending_cmds.pop_front();
        start            <= 1'b1;
        in_func          <= cur_cmd.func;
        in_request_bytes <= cur_cmd.req;
        in_block_address <= cur_cmd.addr;
        in_class_index   <= cur_cmd.cls;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobe is one result; compare it with the oldest prediction.
  always @(posedge clk) begin
    heap_reply_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (predicted_replies.size() == 0) begin
        $display("%0t: result strobe with no transaction outstanding", $time);
        err_count++;
      end else begin
        want = predicted_replies.pop_front();
        check_field("result_address", want.address, out_result_address);
        check_field("block_bytes", 32'(want.bytes), 32'(out_block_bytes));
        check_field("class_free_count", 32'(want.free_cnt), 32'(out_class_free_count));
        check_field("live_blocks", want.live, out_live_blocks);
        check_field("total_allocations", want.allocs, out_total_allocations);
        check_field("bump_bytes_left", want.bump_left, out_bump_bytes_left);
        check_field("status", 32'(want.status), 32'(out_status));
      end
      replies_seen++;
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("segregated_pow2_block_allocator verification failed");
      $finish;
    end
  end

  initial begin
    heap_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass on the reset bounds (heap 0 .. 256 KiB).
    send_idle_pct = 8;
    plan_cmd(mk_cmd(FN_ALLOC, 32'd0));            // zero size
    plan_cmd(mk_cmd(FN_ALLOC, 32'd1));            // smallest class, block at 4
    plan_cmd(mk_cmd(FN_ALLOC, 32'd16));           // smallest class, block at 24
    plan_cmd(mk_cmd(FN_ALLOC, 32'd17));           // rounds up to 32
    plan_cmd(mk_cmd(FN_ALLOC, 32'd65536));        // largest class
    plan_cmd(mk_cmd(FN_ALLOC, 32'd65537));        // too large
    plan_cmd(mk_cmd(FN_ALLOC, 32'hFFFF_FFFF));    // too large, all ones
    plan_cmd(mk_cmd(FN_SIZE, 32'd4));
    plan_cmd(mk_cmd(FN_SIZE, 32'd80));
    plan_cmd(mk_cmd(FN_SIZE, 32'd0));             // null
    plan_cmd(mk_cmd(FN_FREE, 32'd0));             // null
    plan_cmd(mk_cmd(FN_FREE, 32'd24));
    plan_cmd(mk_cmd(FN_FREE, 32'd4));             // link word now holds 24
    plan_cmd(mk_cmd(FN_SIZE, 32'd8));             // header reads a link: bad class
    plan_cmd(mk_cmd(FN_FREE, 32'd8));             // same bad header on free
    plan_cmd(mk_cmd(FN_COUNT, 32'd0));
    plan_cmd(mk_cmd(FN_COUNT, 32'd12));
    plan_cmd(mk_cmd(FN_COUNT, 32'd13));           // class index out of range
    plan_cmd(mk_cmd(FN_COUNT, 32'd15));
    plan_cmd(mk_cmd(FN_ALLOC, 32'd5));            // pops block 4
    plan_cmd(mk_cmd(FN_FREE, 32'hFFFF_0000));     // far outside the store
    plan_cmd(mk_cmd(FN_SIZE, 32'hFFFF_FFFF));
    plan_cmd(mk_cmd(FN_FREE, 32'd262144));        // link word past the store
    repeat (3) plan_cmd(mk_cmd(FN_ALLOC, 32'd65536));  // last one finds heap full
    wait_idle();

    // Move the heap up: old list heads go stale, their links fall off the store.
    write_reg(REG_HEAP_START, 32'h8000_0000);
    write_reg(REG_HEAP_END, 32'h8004_0000);
    for (int c = 0; c < NCLASS; c++) plan_cmd(mk_cmd(FN_ALLOC, 32'd16 << c));
    plan_random(RANDOM_ITEMS);
    wait_idle();

    // Unbounded end: bump allocations run past the store and headers drop.
    send_idle_pct = 79;
    write_reg(REG_HEAP_START, 32'h0000_1000);
    write_reg(REG_HEAP_END, 32'hFFFF_FFFF);
    repeat (5) plan_cmd(mk_cmd(FN_ALLOC, 32'd65536));
    plan_random(RANDOM_ITEMS);
    wait_idle();

    // Empty heap at the top of the address space: no bump allocation fits, so only pops can allocate.
    send_idle_pct = 0;
    write_reg(REG_HEAP_START, 32'hFFFF_FFFF);
    write_reg(REG_HEAP_END, 32'h0000_0000);
    plan_random(40);
    wait_idle();

    // Back to a zero-based heap; old lists and live blocks carry over.
    write_reg(REG_HEAP_START, 32'h0000_0000);
    write_reg(REG_HEAP_END, 32'h0004_0000);
    plan_random(RANDOM_ITEMS);
    wait_idle();

    // Drain: let any stray strobe show up before the verdict.
    repeat (16) @(posedge clk);
    if (err_count == 0 && predicted_replies.size() == 0) begin
      $display("segregated_pow2_block_allocator verification clean");
    end else begin
      $display("segregated_pow2_block_allocator verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/spba_pkg.sv
design/spba_ctrl.sv
design/spba_dp.sv
design/segregated_pow2_block_allocator.sv
design/spba_checker.sv
test/tb_segregated_pow2_block_allocator.sv
